// ===== hw/rtl/mafs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync: shared package
// Types, field codes, widths and the bitrate tables used by the front end,
// the divider, the queue and the back end.
// ----------------------------------------------------------------------------
package mafs_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int WIN_W   = 24;
    localparam int LEN_W   = 12;
    localparam int KBPS_W  = 9;
    localparam int NUM_W   = 26;
    localparam int DEN_W   = 16;
    localparam int QUOT_W  = 12;
    localparam int COEF_W  = 18;
    localparam int PROD_W  = KBPS_W + COEF_W;

    localparam logic [10:0] SYNC_WORD = 11'h7FF;

    // version field codes
    localparam logic [1:0] VER_25   = 2'd0;
    localparam logic [1:0] VER_RSVD = 2'd1;
    localparam logic [1:0] VER_2    = 2'd2;
    localparam logic [1:0] VER_1    = 2'd3;

    // layer field codes
    localparam logic [1:0] LAY_RSVD = 2'd0;
    localparam logic [1:0] LAY_3    = 2'd1;
    localparam logic [1:0] LAY_2    = 2'd2;
    localparam logic [1:0] LAY_1    = 2'd3;

    // sample-rate index codes
    localparam logic [1:0] SRI_44K1 = 2'd0;
    localparam logic [1:0] SRI_48K  = 2'd1;
    localparam logic [1:0] SRI_32K  = 2'd2;
    localparam logic [1:0] SRI_RSVD = 2'd3;

    localparam logic [DEN_W-1:0] RATE_44K1 = 16'd44100;
    localparam logic [DEN_W-1:0] RATE_48K  = 16'd48000;
    localparam logic [DEN_W-1:0] RATE_32K  = 16'd32000;

    // bytes-per-kbit coefficients, with the kbit scale folded in
    localparam logic [COEF_W-1:0] COEF_L1  = 18'd12000;
    localparam logic [COEF_W-1:0] COEF_L23 = 18'd144000;

    localparam logic [LEN_W-1:0] HDR_BYTES = 12'd4;
    localparam logic [1:0]       HDR_LAST  = 2'd3;

    // bitrate tables in kbit/s, indexed by the bitrate index
    localparam logic [KBPS_W-1:0] KBPS_V1_L1 [0:15] = '{
        9'd0,   9'd32,  9'd64,  9'd96,  9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_V1_L2 [0:15] = '{
        9'd0,   9'd32,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,  9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_V1_L3 [0:15] = '{
        9'd0,   9'd32,  9'd40,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_V2_L1 [0:15] = '{
        9'd0,   9'd32,  9'd48,  9'd56,  9'd64,  9'd80,  9'd96,  9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0
    };
    localparam logic [KBPS_W-1:0] KBPS_V2_L23 [0:15] = '{
        9'd0,   9'd8,   9'd16,  9'd24,  9'd32,  9'd40,  9'd48,  9'd56,
        9'd64,  9'd80,  9'd96,  9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

    // one queue entry: a whole 4-byte header or a single body byte
    typedef struct packed {
        logic              is_hdr;
        logic [WORD_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  length;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [KBPS_W-1:0] kbps_lookup(
        input logic [1:0] ver,
        input logic [1:0] lay,
        input logic [3:0] bri
    );
        logic [KBPS_W-1:0] v;
        v = '0;
        if (ver == VER_1) begin
            unique case (lay)
                LAY_1:   v = KBPS_V1_L1[bri];
                LAY_2:   v = KBPS_V1_L2[bri];
                LAY_3:   v = KBPS_V1_L3[bri];
                default: v = '0;
            endcase
        end else begin
            unique case (lay)
                LAY_1:   v = KBPS_V2_L1[bri];
                LAY_2,
                LAY_3:   v = KBPS_V2_L23[bri];
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/mafs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync: frame length divider
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QUOT_W bits, so the divisor starts aligned at bit QUOT_W-1.
// ----------------------------------------------------------------------------
module mafs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mafs_pkg::t_div_req i_req,
    output mafs_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(mafs_pkg::QUOT_W);
    localparam int SH_W  = mafs_pkg::DEN_W + mafs_pkg::QUOT_W - 1;

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [mafs_pkg::NUM_W-1:0]  r_rem;
    logic [SH_W-1:0]             r_den_sh;
    logic [mafs_pkg::QUOT_W-1:0] r_quot;

    logic            w_ge;
    logic [SH_W-1:0] w_diff;

    assign w_ge   = SH_W'(r_rem) >= r_den_sh;
    assign w_diff = SH_W'(r_rem) - r_den_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mafs_pkg::QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: subtract where the shifted divisor fits, shift in the bit
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem    <= i_req.num;
            r_den_sh <= {i_req.den, {(mafs_pkg::QUOT_W - 1){1'b0}}};
            r_quot   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_diff[mafs_pkg::NUM_W-1:0];
            end
            r_quot   <= {r_quot[mafs_pkg::QUOT_W-2:0], w_ge};
            r_den_sh <= r_den_sh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

`ifndef SYNTH
    // a new division never starts on top of one in flight
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");
`endif

endmodule

// ===== hw/rtl/mafs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync: front end
// Accepts stream bytes, scans the 4-byte window for a header, runs the frame
// length division and queues header and body entries for the back end.
// ----------------------------------------------------------------------------
module mafs_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [mafs_pkg::BYTE_W-1:0] i_in_byte,
    output mafs_pkg::t_div_req          o_div_req,
    input  mafs_pkg::t_div_rsp          i_div_rsp,
    output logic                        o_q_push,
    output mafs_pkg::t_entry            o_q_entry,
    input  logic                        i_q_full
);

    mafs_pkg::t_front_state r_state, n_state;

    logic [mafs_pkg::WIN_W-1:0]  r_window,    n_window;
    logic [1:0]                  r_fill,      n_fill;
    logic                        r_in_frame,  n_in_frame;
    logic [mafs_pkg::LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [mafs_pkg::LEN_W-1:0]  r_cur_len,   n_cur_len;
    logic [mafs_pkg::WORD_W-1:0] r_hdr,       n_hdr;

    logic                         w_accept;
    logic [mafs_pkg::WORD_W-1:0]  w_word;
    logic [1:0]                   w_ver;
    logic [1:0]                   w_lay;
    logic [3:0]                   w_bri;
    logic [1:0]                   w_sri;
    logic [mafs_pkg::KBPS_W-1:0]  w_kbps;
    logic [mafs_pkg::DEN_W-1:0]   w_base;
    logic [mafs_pkg::DEN_W-1:0]   w_rate;
    logic [mafs_pkg::COEF_W-1:0]  w_coef;
    logic [mafs_pkg::PROD_W-1:0]  w_prod;
    logic                         w_hdr_ok;
    logic [mafs_pkg::LEN_W-1:0]   w_sum;
    logic [mafs_pkg::LEN_W-1:0]   w_len;

    assign o_full   = (r_state != mafs_pkg::FS_IDLE) || i_q_full;
    assign w_accept = i_push && !o_full;

    // header fields of the candidate word
    assign w_word = {r_window, i_in_byte};
    assign w_ver  = w_word[20:19];
    assign w_lay  = w_word[18:17];
    assign w_bri  = w_word[15:12];
    assign w_sri  = w_word[11:10];
    assign w_kbps = mafs_pkg::kbps_lookup(w_ver, w_lay, w_bri);

    always_comb begin
        unique case (w_sri)
            mafs_pkg::SRI_44K1: w_base = mafs_pkg::RATE_44K1;
            mafs_pkg::SRI_48K:  w_base = mafs_pkg::RATE_48K;
            mafs_pkg::SRI_32K:  w_base = mafs_pkg::RATE_32K;
            default:            w_base = mafs_pkg::RATE_44K1;
        endcase
    end

    always_comb begin
        unique case (w_ver)
            mafs_pkg::VER_1: w_rate = w_base;
            mafs_pkg::VER_2: w_rate = w_base >> 1;
            default:         w_rate = w_base >> 2;
        endcase
    end

    assign w_coef = (w_lay == mafs_pkg::LAY_1) ? mafs_pkg::COEF_L1 : mafs_pkg::COEF_L23;
    assign w_prod = mafs_pkg::PROD_W'(w_kbps) * mafs_pkg::PROD_W'(w_coef);

    assign w_hdr_ok = (w_word[31:21] == mafs_pkg::SYNC_WORD)
                   && (w_ver != mafs_pkg::VER_RSVD)
                   && (w_lay != mafs_pkg::LAY_RSVD)
                   && (w_sri != mafs_pkg::SRI_RSVD)
                   && (w_kbps != '0);

    // frame length from the quotient: layer 1 counts 4-byte slots
    assign w_sum = i_div_rsp.quot + mafs_pkg::LEN_W'(r_hdr[9]);
    assign w_len = (r_hdr[18:17] == mafs_pkg::LAY_1) ? {w_sum[mafs_pkg::LEN_W-3:0], 2'b00}
                                                     : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mafs_pkg::FS_IDLE;
            r_window     <= '0;
            r_fill       <= '0;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_cur_len    <= '0;
        end else begin
            r_state      <= n_state;
            r_window     <= n_window;
            r_fill       <= n_fill;
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_cur_len    <= n_cur_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    always_comb begin
        n_state      = r_state;
        n_window     = r_window;
        n_fill       = r_fill;
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        n_cur_len    = r_cur_len;
        n_hdr        = r_hdr;

        o_div_req.start = 1'b0;
        o_div_req.num   = w_prod[mafs_pkg::NUM_W-1:0];
        o_div_req.den   = w_rate;

        o_q_push         = 1'b0;
        o_q_entry.is_hdr = 1'b0;
        o_q_entry.data   = {{(mafs_pkg::WORD_W - mafs_pkg::BYTE_W){1'b0}}, i_in_byte};
        o_q_entry.last   = 1'b0;
        o_q_entry.length = r_cur_len;

        unique case (r_state)
            mafs_pkg::FS_IDLE: begin
                if (w_accept) begin
                    if (r_in_frame) begin
                        // forward a body byte
                        o_q_push = 1'b1;
                        if (r_bytes_left <= mafs_pkg::LEN_W'(1)) begin
                            o_q_entry.last = 1'b1;
                            n_in_frame     = 1'b0;
                            n_bytes_left   = '0;
                            n_window       = '0;
                            n_fill         = '0;
                        end else begin
                            n_bytes_left = r_bytes_left - 1'b1;
                        end
                    end else if (r_fill != 2'd3) begin
                        n_window = w_word[mafs_pkg::WIN_W-1:0];
                        n_fill   = r_fill + 1'b1;
                    end else if (w_hdr_ok) begin
                        // hold the header and size the frame
                        o_div_req.start = 1'b1;
                        n_hdr           = w_word;
                        n_window        = '0;
                        n_fill          = '0;
                        n_state         = mafs_pkg::FS_DIV;
                    end else begin
                        n_window = w_word[mafs_pkg::WIN_W-1:0];
                    end
                end
            end
            mafs_pkg::FS_DIV: begin
                if (i_div_rsp.done) begin
                    n_cur_len    = w_len;
                    n_bytes_left = w_len - mafs_pkg::HDR_BYTES;
                    n_in_frame   = 1'b1;
                    n_state      = mafs_pkg::FS_PUSH;
                end
            end
            mafs_pkg::FS_PUSH: begin
                o_q_entry.is_hdr = 1'b1;
                o_q_entry.data   = r_hdr;
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = mafs_pkg::FS_IDLE;
                end
            end
            default: begin
                n_state = mafs_pkg::FS_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // a division result only arrives while a header waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == mafs_pkg::FS_DIV))
        else $error("divider result outside of header sizing");
    // a queued header always opens a frame
    a_hdr_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_entry.is_hdr) |=> (r_in_frame && r_bytes_left != '0))
        else $error("header queued without an open frame");
`endif

endmodule

// ===== hw/rtl/mafs_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync: entry queue
// Small register queue that lets the front end and back end stall apart.
// DEPTH must be a power of two, at least 2; the queue itself does not check this.
// ----------------------------------------------------------------------------
module mafs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mafs_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output mafs_pkg::t_entry o_head,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mafs_pkg::t_entry r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("entry queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("entry queue underflow");
`endif

endmodule

// ===== hw/rtl/mafs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync: back end
// Output register that unpacks queue entries into single-byte results:
// a header entry gives four bytes, a body entry one.
// ----------------------------------------------------------------------------
module mafs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mafs_pkg::t_entry            i_head,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [mafs_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_frame_first,
    output logic                        o_frame_last,
    output logic [mafs_pkg::LEN_W-1:0]  o_frame_length
);

    logic             r_valid, n_valid;
    logic [1:0]       r_idx,   n_idx;
    mafs_pkg::t_entry r_entry, n_entry;

    logic                        w_take;
    logic [mafs_pkg::BYTE_W-1:0] w_hdr_byte;

    // free the register when empty or when its last byte leaves
    assign w_take = !r_valid
                 || (i_pop && (!r_entry.is_hdr || r_idx == mafs_pkg::HDR_LAST));

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        n_entry = r_entry;
        o_q_pop = 1'b0;
        if (w_take) begin
            if (!i_q_empty) begin
                o_q_pop = 1'b1;
                n_entry = i_head;
                n_idx   = '0;
                n_valid = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_pop) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        case (r_idx)
            2'd0:    w_hdr_byte = r_entry.data[31:24];
            2'd1:    w_hdr_byte = r_entry.data[23:16];
            2'd2:    w_hdr_byte = r_entry.data[15:8];
            default: w_hdr_byte = r_entry.data[7:0];
        endcase
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_entry.is_hdr ? w_hdr_byte : r_entry.data[7:0];
    assign o_frame_first  = r_entry.is_hdr && (r_idx == '0);
    assign o_frame_last   = !r_entry.is_hdr && r_entry.last;
    assign o_frame_length = r_entry.length;

`ifndef SYNTH
    // the first header byte is always followed by the rest of the header
    a_hdr_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && o_frame_first) |=> (!o_empty && !o_frame_first))
        else $error("header bytes split apart");
`endif

endmodule

// ===== hw/rtl/mpeg_audio_frame_sync.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio frame sync
// Finds MPEG audio frame headers in a byte stream and forwards whole frames
// with first/last marks and the computed frame length.
// ----------------------------------------------------------------------------
// Push one stream byte per transaction; pop one frame byte per transaction.
// Bytes between frames are dropped. A scanned byte or a byte inside a frame
// is taken without stalling while the entry queue has room. The byte that
// completes a valid header starts the shift-subtract divider that computes
// the frame length (one quotient bit per cycle); the front end then takes the
// length from the divider and queues the header; full stays high meanwhile, and
// longer while the queue is full. The header then leaves as four results, the
// first marked frame_first, and the last body byte is marked frame_last. An
// entry queue of QUEUE_DEPTH entries sits between the front end and the output
// register, so input keeps flowing while results wait to be popped until the
// queue fills; full then holds until the receiver pops.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_sync #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mafs_pkg::BYTE_W-1:0] i_in_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [mafs_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_frame_first,
    output logic                        o_frame_last,
    output logic [mafs_pkg::LEN_W-1:0]  o_frame_length
);

    mafs_pkg::t_div_req w_div_req;
    mafs_pkg::t_div_rsp w_div_rsp;
    mafs_pkg::t_entry   w_q_in;
    mafs_pkg::t_entry   w_q_head;
    logic               w_q_push;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;

    // front end: scan, classify and size frames
    mafs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in_byte (i_in_byte),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_q_push  (w_q_push),
        .o_q_entry (w_q_in),
        .i_q_full  (w_q_full)
    );

    // frame length divider
    mafs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // decouple the two sides
    mafs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_head  (w_q_head),
        .o_empty (w_q_empty)
    );

    // back end: unpack entries into result bytes
    mafs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_q_head),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_out_byte     (o_out_byte),
        .o_frame_first  (o_frame_first),
        .o_frame_last   (o_frame_last),
        .o_frame_length (o_frame_length)
    );

endmodule
